// ----- rtl/sab_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sab_pkg;

  // Source store geometry
  localparam int SRC_MAX_WIDTH  = 64;
  localparam int SRC_MAX_HEIGHT = 64;
  localparam int STORE_DEPTH    = SRC_MAX_WIDTH * SRC_MAX_HEIGHT;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int COL_W          = (SRC_MAX_WIDTH < 2) ? 1 : $clog2(SRC_MAX_WIDTH);
  localparam int ROW_W          = (SRC_MAX_HEIGHT < 2) ? 1 : $clog2(SRC_MAX_HEIGHT);
  // quotient bits: one divider stage per bit
  localparam int QW             = (COL_W > ROW_W) ? COL_W : ROW_W;

  // Field widths
  localparam int COORD_W   = 12;
  localparam int TEX_IDX_W = 12;
  localparam int PIX_W     = 32;
  localparam int RECT_W    = 13;
  localparam int SIZE_W    = 7;
  localparam int ALPHA_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = RECT_W;
  localparam int SPAN_W    = RECT_W;
  localparam int NUM_W     = SPAN_W + SIZE_W;
  localparam int CH_W      = 8;
  localparam int NUM_CH    = 3;

  // Blend arithmetic: weights out of 255*255, rounding by reciprocal multiply
  localparam int W_W     = 16;
  localparam int P_W     = CH_W + W_W;
  localparam int X_W     = P_W + 1;
  localparam int Q_W     = CH_W + 1;
  localparam int DEN_W   = 17;
  localparam int RECIP_W = 16;
  localparam int RECIP_SHIFT = 32;
  localparam logic [W_W-1:0]     ALPHA_ONE   = 16'd65025;
  localparam logic [DEN_W-1:0]   BLEND_DEN   = 17'd130050;
  localparam logic [RECIP_W-1:0] BLEND_RECIP = 16'd33025;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_BLEND = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RECT_LEFT     = 3'd0,
    CFG_RECT_TOP      = 3'd1,
    CFG_RECT_RIGHT    = 3'd2,
    CFG_RECT_BOTTOM   = 3'd3,
    CFG_SOURCE_WIDTH  = 3'd4,
    CFG_SOURCE_HEIGHT = 3'd5,
    CFG_GLOBAL_ALPHA  = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic signed [RECT_W-1:0] left;
    logic signed [RECT_W-1:0] top;
    logic signed [RECT_W-1:0] right;
    logic signed [RECT_W-1:0] bottom;
    logic [SIZE_W-1:0]        width;
    logic [SIZE_W-1:0]        height;
  } geom_t;

  typedef struct packed {
    logic                 op;
    logic                 in_rect;
    logic [TEX_IDX_W-1:0] idx;
    logic [PIX_W-1:0]     tval;
    logic [PIX_W-1:0]     dpix;
  } item_t;

endpackage

`default_nettype wire

// ----- rtl/sab_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sab_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/sab_index.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Rectangle test and nearest-neighbor texel address: offset*size, then a
// restoring divide by the span, one quotient bit per stage.
module sab_index import sab_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 take,
  input  wire logic                 opcode,
  input  wire logic [TEX_IDX_W-1:0] texel_index,
  input  wire logic [PIX_W-1:0]     texel_value,
  input  wire logic [COORD_W-1:0]   pixel_x,
  input  wire logic [COORD_W-1:0]   pixel_y,
  input  wire logic [PIX_W-1:0]     dest_pixel,
  input  wire geom_t                geom,
  output logic                      vld,
  output item_t                     item,
  output logic [ADDR_W-1:0]         addr
);

  logic signed [RECT_W:0] x14, y14, left14, top14, right14, bottom14;
  logic signed [RECT_W:0] offx_c, offy_c, spanx_c, spany_c;
  logic                   inside_c;
  logic [SIZE_W-1:0]      swc_c, shc_c;

  assign x14      = $signed({2'b00, pixel_x});
  assign y14      = $signed({2'b00, pixel_y});
  assign left14   = {geom.left[RECT_W-1], geom.left};
  assign top14    = {geom.top[RECT_W-1], geom.top};
  assign right14  = {geom.right[RECT_W-1], geom.right};
  assign bottom14 = {geom.bottom[RECT_W-1], geom.bottom};
  assign offx_c   = x14 - left14;
  assign offy_c   = y14 - top14;
  assign spanx_c  = right14 - left14;
  assign spany_c  = bottom14 - top14;
  assign inside_c = (x14 >= left14) && (x14 < right14) &&
                    (y14 >= top14) && (y14 < bottom14);
  assign swc_c = (geom.width > SIZE_W'(SRC_MAX_WIDTH)) ? SIZE_W'(SRC_MAX_WIDTH)
                                                        : geom.width;
  assign shc_c = (geom.height > SIZE_W'(SRC_MAX_HEIGHT)) ? SIZE_W'(SRC_MAX_HEIGHT)
                                                          : geom.height;

  // Stage 1: captured item with offsets and spans
  logic              v1;
  item_t             it1;
  logic [SPAN_W-1:0] offx1, offy1, spanx1, spany1;
  logic [SIZE_W-1:0] swc1, shc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1.op      <= opcode;
      it1.in_rect <= inside_c;
      it1.idx     <= texel_index;
      it1.tval    <= texel_value;
      it1.dpix    <= dest_pixel;
      offx1       <= offx_c[SPAN_W-1:0];
      offy1       <= offy_c[SPAN_W-1:0];
      spanx1      <= spanx_c[SPAN_W-1:0];
      spany1      <= spany_c[SPAN_W-1:0];
      swc1        <= swc_c;
      shc1        <= shc_c;
    end
  end

  // Stage 2 (entry 0 of the divider chain): numerators
  logic              dv   [0:QW];
  item_t             dit  [0:QW];
  logic [NUM_W-1:0]  drx  [0:QW];
  logic [NUM_W-1:0]  dry  [0:QW];
  logic [SPAN_W-1:0] dspx [0:QW];
  logic [SPAN_W-1:0] dspy [0:QW];
  logic [QW-1:0]     dqx  [0:QW];
  logic [QW-1:0]     dqy  [0:QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dit[0]  <= it1;
      drx[0]  <= NUM_W'(offx1) * NUM_W'(swc1);
      dry[0]  <= NUM_W'(offy1) * NUM_W'(shc1);
      dspx[0] <= spanx1;
      dspy[0] <= spany1;
      dqx[0]  <= '0;
      dqy[0]  <= '0;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int SH = QW - 1 - k;
    logic [NUM_W-1:0] dx, dy;
    logic             gex, gey;

    assign dx  = NUM_W'(dspx[k]) << SH;
    assign dy  = NUM_W'(dspy[k]) << SH;
    assign gex = drx[k] >= dx;
    assign gey = dry[k] >= dy;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dit[k+1]  <= dit[k];
        dspx[k+1] <= dspx[k];
        dspy[k+1] <= dspy[k];
        drx[k+1]  <= gex ? drx[k] - dx : drx[k];
        dry[k+1]  <= gey ? dry[k] - dy : dry[k];
        dqx[k+1]  <= QW'({dqx[k], gex});
        dqy[k+1]  <= QW'({dqy[k], gey});
      end
    end
  end

  assign vld  = dv[QW];
  assign item = dit[QW];
  assign addr = ADDR_W'(COL_W'(dqx[QW])) +
                ADDR_W'(ROW_W'(dqy[QW])) * ADDR_W'(SRC_MAX_WIDTH);

endmodule

`default_nettype wire

// ----- rtl/sab_blend.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Per-channel lerp d*(1-w) + s*w with w out of 255*255, rounded half up.
// The divide by 2*65025 is a reciprocal multiply plus one correction step.
module sab_blend import sab_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               vld_in,
  input  wire logic               inside_in,
  input  wire logic [PIX_W-1:0]   dpix_in,
  input  wire logic [PIX_W-1:0]   src_in,
  input  wire logic [ALPHA_W-1:0] global_alpha,
  output logic                    out_valid,
  output logic [PIX_W-1:0]        result_pixel,
  output logic                    was_blended
);

  logic [6:1] v;
  logic [5:1] ins;
  logic [PIX_W-1:0] d1, d2, d3, d4, d5;
  logic [NUM_CH*CH_W-1:0] s1;
  logic [W_W-1:0] w1;
  logic [P_W-1:0] p1 [0:NUM_CH-1];
  logic [P_W-1:0] p2 [0:NUM_CH-1];
  logic [X_W-1:0] x3 [0:NUM_CH-1];
  logic [X_W-1:0] x4 [0:NUM_CH-1];
  logic [X_W-1:0] x5 [0:NUM_CH-1];
  logic [Q_W-1:0] q4 [0:NUM_CH-1];
  logic [Q_W-1:0] q5 [0:NUM_CH-1];
  logic [X_W-1:0] m5 [0:NUM_CH-1];

  logic [X_W+RECIP_W-1:0] est  [0:NUM_CH-1];
  logic [X_W-1:0]         rem  [0:NUM_CH-1];
  logic [Q_W-1:0]         qfin [0:NUM_CH-1];

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      est[ch]  = (X_W+RECIP_W)'(x3[ch]) * (X_W+RECIP_W)'(BLEND_RECIP);
      rem[ch]  = x5[ch] - m5[ch];
      qfin[ch] = (rem[ch] >= X_W'(BLEND_DEN)) ? q5[ch] + Q_W'(1) : q5[ch];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:1], vld_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ins <= {ins[4:1], inside_in};
      d1  <= dpix_in;
      d2  <= d1;
      d3  <= d2;
      d4  <= d3;
      d5  <= d4;
      s1  <= src_in[PIX_W-1:CH_W];
      w1  <= W_W'(src_in[CH_W-1:0]) * W_W'(global_alpha);
      for (int ch = 0; ch < NUM_CH; ch++) begin
        p1[ch] <= P_W'(d1[PIX_W-CH_W*(ch+1) +: CH_W]) * P_W'(ALPHA_ONE - w1);
        p2[ch] <= P_W'(s1[NUM_CH*CH_W-CH_W*(ch+1) +: CH_W]) * P_W'(w1);
        // 2*num + 65025
        x3[ch] <= {p1[ch] + p2[ch], 1'b0} + X_W'(ALPHA_ONE);
        x4[ch] <= x3[ch];
        q4[ch] <= Q_W'(est[ch] >> RECIP_SHIFT);
        x5[ch] <= x4[ch];
        q5[ch] <= q4[ch];
        m5[ch] <= X_W'(X_W'(q4[ch]) * X_W'(BLEND_DEN));
      end
      if (ins[5]) begin
        result_pixel <= {qfin[0][CH_W-1:0], qfin[1][CH_W-1:0],
                         qfin[2][CH_W-1:0], CH_W'(0)};
      end else begin
        result_pixel <= d5;
      end
      was_blended <= ins[5];
    end
  end

  assign out_valid = v[6];

endmodule

`default_nettype wire

// ----- rtl/scaled_alpha_blit_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Scaled alpha blitter. Load items (opcode 0) write one 32-bit texel into a
// 4096-word source store; blend items (opcode 1) return one pixel each: inside
// the destination rectangle the nearest source texel is blended over
// dest_pixel (alpha byte of the result zero, was_blended 1), outside it
// dest_pixel comes back unchanged. The block takes one item every cycle
// while in_stall is low; a blend result passes through rectangle test and
// one-bit-per-stage index division, then the store read port, then blend
// arithmetic. Loads write the store at the same stage where blends read it,
// so items see the store in transfer order. in_stall is high only while a
// finished result waits on out_stall. Configuration registers are to be
// written only while no item is in flight; the block does not enforce this.
module scaled_alpha_blit_top import sab_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  opcode,
  input  wire logic [TEX_IDX_W-1:0]  texel_index,
  input  wire logic [PIX_W-1:0]      texel_value,
  input  wire logic [COORD_W-1:0]    pixel_x,
  input  wire logic [COORD_W-1:0]    pixel_y,
  input  wire logic [PIX_W-1:0]      dest_pixel,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PIX_W-1:0]           result_pixel,
  output logic                       was_blended
);

  geom_t              geom;
  logic [ALPHA_W-1:0] global_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.left    <= '0;
      geom.top     <= '0;
      geom.right   <= '0;
      geom.bottom  <= '0;
      geom.width   <= SIZE_W'(SRC_MAX_WIDTH);
      geom.height  <= SIZE_W'(SRC_MAX_HEIGHT);
      global_alpha <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_RECT_LEFT:     geom.left    <= cfg_data;
        CFG_RECT_TOP:      geom.top     <= cfg_data;
        CFG_RECT_RIGHT:    geom.right   <= cfg_data;
        CFG_RECT_BOTTOM:   geom.bottom  <= cfg_data;
        CFG_SOURCE_WIDTH:  geom.width   <= cfg_data[SIZE_W-1:0];
        CFG_SOURCE_HEIGHT: geom.height  <= cfg_data[SIZE_W-1:0];
        CFG_GLOBAL_ALPHA:  global_alpha <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // whole pipeline freezes while the output register holds a stalled result
  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  logic              f_vld;
  item_t             f_item;
  logic [ADDR_W-1:0] f_addr;

  sab_index u_index (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .take        (in_valid),
    .opcode      (opcode),
    .texel_index (texel_index),
    .texel_value (texel_value),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .dest_pixel  (dest_pixel),
    .geom        (geom),
    .vld         (f_vld),
    .item        (f_item),
    .addr        (f_addr)
  );

  logic             ram_we, ram_re;
  logic [PIX_W-1:0] ram_rdata;

  assign ram_we = advance && f_vld && (f_item.op == OP_LOAD) &&
                  ({1'b0, f_item.idx} < (TEX_IDX_W+1)'(STORE_DEPTH));
  assign ram_re = advance && f_vld && (f_item.op == OP_BLEND);

  sab_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ADDR_W'(f_item.idx)),
    .wdata (f_item.tval),
    .re    (ram_re),
    .raddr (f_addr),
    .rdata (ram_rdata)
  );

  // read stage: sideband that lines up with the registered store data
  logic             r_vld;
  logic             r_inside;
  logic [PIX_W-1:0] r_dpix;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld <= 1'b0;
    end else if (advance) begin
      r_vld <= f_vld && (f_item.op == OP_BLEND);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      r_inside <= f_item.in_rect;
      r_dpix   <= f_item.dpix;
    end
  end

  sab_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .vld_in       (r_vld),
    .inside_in    (r_inside),
    .dpix_in      (r_dpix),
    .src_in       (ram_rdata),
    .global_alpha (global_alpha),
    .out_valid    (out_valid),
    .result_pixel (result_pixel),
    .was_blended  (was_blended)
  );

  a_alpha_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_blended |-> result_pixel[CH_W-1:0] == '0)
    else $error("blended result with nonzero alpha byte");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(f_vld) && $stable(f_addr))
    else $error("index pipeline moved while output stalled");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    advance && f_vld && (f_item.op == OP_LOAD) |=> !r_vld)
    else $error("load transfer entered the blend path");

endmodule

`default_nettype wire
